FILE: rtl/core/pwst_pkg.sv
// ----------------------------------------------------------------------------
// pwst_pkg - shared types and constants for the wheel PI / pan-tilt block
// Sequencer states, register indexes, duty and servo limits, camera window.
// ----------------------------------------------------------------------------
package pwst_pkg;

  localparam int CFG_IDX_W      = 3;
  localparam int PIX_W          = 9;
  localparam int DUTY_W         = 8;
  localparam int SERVO_W        = 7;
  localparam int OUT_TDATA_W    = 32;
  localparam int INTEG_INT_BITS = 24;

  localparam logic [CFG_IDX_W-1:0] REG_KP_LEFT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI_LEFT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KP_RIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KI_RIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLIP     = 3'd4;

  localparam int KP_RESET_Q16 = 328;
  localparam int KI_RESET_Q16 = 19661;
  localparam int SLIP_RESET   = 18;

  localparam int DUTY_STOP = 100;
  localparam int DUTY_MAX  = 200;

  localparam int CAM_WIDTH  = 260;
  localparam int CAM_HEIGHT = 280;
  localparam int DEADBAND   = 20;
  localparam int SERVO_MIN  = 20;
  localparam int SERVO_MAX  = 120;
  localparam int SERVO_HOME = 70;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORR,
    ST_KP,
    ST_HI,
    ST_LO,
    ST_INT,
    ST_DUTY,
    ST_DONE
  } pwst_state_t;

  typedef struct packed {
    logic             upd;
    logic             seen;
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
  } pwst_cam_t;

endpackage

FILE: rtl/core/pwst_mul.sv
// ----------------------------------------------------------------------------
// pwst_mul - shared signed by unsigned multiplier
// One product per cycle with the result registered.
// ----------------------------------------------------------------------------
module pwst_mul #(
  parameter int A_W = 21,
  parameter int B_W = 16
) (
  input  logic                     clk,
  input  logic signed [A_W-1:0]    a,
  input  logic        [B_W-1:0]    b,
  output logic signed [A_W+B_W-1:0] prod
);

  logic signed [A_W+B_W:0] full;

  assign full = a * $signed({1'b0, b});

  always_ff @(posedge clk) begin
    prod <= full[A_W+B_W-1:0];
  end

endmodule

FILE: rtl/core/pwst_servo.sv
// ----------------------------------------------------------------------------
// pwst_servo - pan and tilt tracking
// Step each servo by one toward the object outside the deadband, in 20..120.
// ----------------------------------------------------------------------------
module pwst_servo import pwst_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  pwst_cam_t          cam,
  output logic [SERVO_W-1:0] pan,
  output logic [SERVO_W-1:0] tilt
);

  localparam logic [PIX_W:0] X_HI = (PIX_W+1)'(CAM_WIDTH / 2 + DEADBAND);
  localparam logic [PIX_W:0] X_LO = (PIX_W+1)'(CAM_WIDTH / 2 - DEADBAND);
  localparam logic [PIX_W:0] Y_HI = (PIX_W+1)'(CAM_HEIGHT / 2 + DEADBAND);
  localparam logic [PIX_W:0] Y_LO = (PIX_W+1)'(CAM_HEIGHT / 2 - DEADBAND);
  localparam logic [SERVO_W-1:0] S_MIN  = SERVO_W'(SERVO_MIN);
  localparam logic [SERVO_W-1:0] S_MAX  = SERVO_W'(SERVO_MAX);
  localparam logic [SERVO_W-1:0] S_HOME = SERVO_W'(SERVO_HOME);

  logic [PIX_W:0] x_ext, y_ext;

  assign x_ext = {1'b0, cam.x};
  assign y_ext = {1'b0, cam.y};

  always_ff @(posedge clk) begin
    if (rst) begin
      pan  <= S_HOME;
      tilt <= S_HOME;
    end else if (cam.upd && cam.seen) begin
      if (x_ext > X_HI && pan > S_MIN) begin
        pan <= pan - 1'b1;
      end else if (x_ext < X_LO && pan < S_MAX) begin
        pan <= pan + 1'b1;
      end
      if (y_ext > Y_HI && tilt < S_MAX) begin
        tilt <= tilt + 1'b1;
      end else if (y_ext < Y_LO && tilt > S_MIN) begin
        tilt <= tilt - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/dual_wheel_pi_speed_with_pan_tilt_track.sv
// ----------------------------------------------------------------------------
// dual_wheel_pi_speed_with_pan_tilt_track - two wheel PI speed loop
// with slip correction and camera pan/tilt tracking
//
//   channel   direction  handshake              content
//   s_*       in         s_tvalid / s_tready    speeds, targets, object pos
//   m_*       out        m_tvalid / m_tready    duties, pan, tilt
//   cfg_*     in         cfg_valid / cfg_ready  gain register writes
//
// Once the input word is taken, the sequencer applies the slip product,
// then for each wheel forms the gain product and the two integral products,
// updates the integrator and clamps the duty, and finally loads the output.
// The input side is ready only while the sequencer is idle, so a new word
// is taken only after the result of the last one has been loaded.
// A stalled result holds the sequencer in its last state.
// Reset clears the integrators, homes the servos and loads default gains.
// ----------------------------------------------------------------------------
module dual_wheel_pi_speed_with_pan_tilt_track import pwst_pkg::*; #(
  parameter int SPEED_BITS     = 11,
  parameter int GAIN_FRAC_BITS = 16,
  localparam int IN_W          = 4 * SPEED_BITS + 2 * PIX_W,
  localparam int IN_TDATA_W    = ((IN_W + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // order_left, order_right, speed_left, speed_right, object_x, object_y
  input  logic [IN_TDATA_W-1:0]     s_tdata,
  // going_straight, object_seen
  input  logic [1:0]                s_tuser,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // duty_left, duty_right, pan_cmd, tilt_cmd
  output logic [OUT_TDATA_W-1:0]    m_tdata,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [GAIN_FRAC_BITS-1:0] cfg_data
);

  localparam int SB      = SPEED_BITS;
  localparam int GF      = GAIN_FRAC_BITS;
  localparam int ERR_W   = SB + 10;
  localparam int MA_W    = (ERR_W > GF + 1) ? ERR_W : GF + 1;
  localparam int PROD_W  = MA_W + GF;
  localparam int P_W     = ERR_W + GF;
  localparam int INTEG_W = INTEG_INT_BITS + GF;
  localparam int DI_W    = P_W + 1;
  localparam int SUM_W   = ((INTEG_W > DI_W) ? INTEG_W : DI_W) + 1;
  localparam int DS_W    = ((INTEG_W > P_W) ? INTEG_W : P_W) + 2;
  localparam int RST_SHL = (GF >= 16) ? GF - 16 : 0;
  localparam int RST_SHR = (GF < 16) ? 16 - GF : 0;
  localparam logic [GF-1:0] KP_RESET = GF'((KP_RESET_Q16 << RST_SHL) >> RST_SHR);
  localparam logic [GF-1:0] KI_RESET = GF'((KI_RESET_Q16 << RST_SHL) >> RST_SHR);
  localparam logic [DS_W-1:0] DUTY_BIAS = DS_W'(DUTY_STOP) << GF;
  localparam logic [DS_W-GF-1:0] DUTY_TOP = (DS_W-GF)'(DUTY_MAX);

  pwst_state_t state, state_next;

  logic signed [SB-1:0] ol_in, or_in, sl_in, sr_in;
  logic signed [SB:0]   diff_in;
  logic signed [SB-1:0] ol, orr, sl, sr;
  logic                 straight;
  logic                 side;

  logic [GF-1:0] kp_l, ki_l, kp_r, ki_r;
  logic [7:0]    slip;

  logic signed [MA_W-1:0]    mul_a;
  logic        [GF-1:0]      mul_b;
  logic signed [PROD_W-1:0]  prod;

  logic signed [ERR_W-1:0]   err_l, err_r, corr;
  logic signed [P_W-1:0]     p, acc;
  logic signed [INTEG_W-1:0] integ_l, integ_r, integ_sel, integ_sat;
  logic signed [SUM_W-1:0]   sum_i;
  logic [SUM_W-INTEG_W:0]    sum_top;
  logic [DS_W-1:0]           dsum;
  logic [DUTY_W-1:0]         duty_l, duty_r, duty_val;
  logic [SERVO_W-1:0]        pan, tilt;
  logic                      in_acc;
  pwst_cam_t                 cam;

  assign ol_in   = s_tdata[SB-1:0];
  assign or_in   = s_tdata[2*SB-1:SB];
  assign sl_in   = s_tdata[3*SB-1:2*SB];
  assign sr_in   = s_tdata[4*SB-1:3*SB];
  assign diff_in = (SB+1)'(sl_in) - (SB+1)'(sr_in);
  assign in_acc  = s_tvalid && s_tready;

  assign cam.upd  = in_acc;
  assign cam.seen = s_tuser[1];
  assign cam.x    = s_tdata[4*SB+PIX_W-1:4*SB];
  assign cam.y    = s_tdata[4*SB+2*PIX_W-1:4*SB+PIX_W];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_l <= KP_RESET;
      ki_l <= KI_RESET;
      kp_r <= KP_RESET;
      ki_r <= KI_RESET;
      slip <= 8'(SLIP_RESET);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KP_LEFT:  kp_l <= cfg_data;
        REG_KI_LEFT:  ki_l <= cfg_data;
        REG_KP_RIGHT: kp_r <= cfg_data;
        REG_KI_RIGHT: ki_r <= cfg_data;
        REG_SLIP:     slip <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        mul_a    = MA_W'(diff_in);
        mul_b    = GF'(slip);
        if (s_tvalid) begin
          state_next = ST_CORR;
        end
      end
      ST_CORR: state_next = ST_KP;
      ST_KP: begin
        mul_a      = side ? MA_W'(err_r) : MA_W'(err_l);
        mul_b      = side ? kp_r : kp_l;
        state_next = ST_HI;
      end
      ST_HI: begin
        mul_a      = MA_W'($signed(prod[P_W-1:GF]));
        mul_b      = side ? ki_r : ki_l;
        state_next = ST_LO;
      end
      ST_LO: begin
        mul_a      = MA_W'({1'b0, p[GF-1:0]});
        mul_b      = side ? ki_r : ki_l;
        state_next = ST_INT;
      end
      ST_INT: state_next = ST_DUTY;
      ST_DUTY: state_next = side ? ST_DONE : ST_KP;
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  pwst_mul #(
    .A_W (MA_W),
    .B_W (GF)
  ) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  pwst_servo u_servo (
    .clk  (clk),
    .rst  (rst),
    .cam  (cam),
    .pan  (pan),
    .tilt (tilt)
  );

  assign corr      = straight ? prod[ERR_W-1:0] : '0;
  assign integ_sel = side ? integ_r : integ_l;
  assign sum_i     = SUM_W'(integ_sel) + SUM_W'(acc) + SUM_W'({1'b0, prod[2*GF-1:GF]});
  assign sum_top   = sum_i[SUM_W-1:INTEG_W-1];

  always_comb begin
    if ((&sum_top) || !(|sum_top)) begin
      integ_sat = sum_i[INTEG_W-1:0];
    end else if (sum_i[SUM_W-1]) begin
      integ_sat = {1'b1, {(INTEG_W-1){1'b0}}};
    end else begin
      integ_sat = {1'b0, {(INTEG_W-1){1'b1}}};
    end
  end

  assign dsum = DS_W'(integ_sel) + DS_W'(p) + DUTY_BIAS;

  always_comb begin
    if (dsum[DS_W-1]) begin
      duty_val = '0;
    end else if (dsum[DS_W-1:GF] > DUTY_TOP) begin
      duty_val = DUTY_W'(DUTY_MAX);
    end else begin
      duty_val = dsum[GF+DUTY_W-1:GF];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ol       <= ol_in;
      orr      <= or_in;
      sl       <= sl_in;
      sr       <= sr_in;
      straight <= s_tuser[0];
    end
    if (state == ST_CORR) begin
      err_l <= ERR_W'(ol) - ERR_W'(sl) - corr;
      err_r <= ERR_W'(orr) - ERR_W'(sr) + corr;
    end
    if (state == ST_HI) begin
      p <= prod[P_W-1:0];
    end
    if (state == ST_LO) begin
      acc <= prod[P_W-1:0];
    end
    if (state == ST_DUTY && !side) begin
      duty_l <= duty_val;
    end
    if (state == ST_DUTY && side) begin
      duty_r <= duty_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side    <= 1'b0;
      integ_l <= '0;
      integ_r <= '0;
    end else begin
      if (state == ST_CORR) begin
        side <= 1'b0;
      end else if (state == ST_DUTY) begin
        side <= 1'b1;
      end
      if (state == ST_INT && !side) begin
        integ_l <= integ_sat;
      end
      if (state == ST_INT && side) begin
        integ_r <= integ_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {2'b00, tilt, pan, duty_r, duty_l};
    end
  end

endmodule

FILE: rtl/core/pwst_chk.sv
// ----------------------------------------------------------------------------
// pwst_chk - port checker for the wheel PI / pan-tilt block
// Watches the stream ports for result ranges and sequencing.
// ----------------------------------------------------------------------------
module pwst_chk import pwst_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  a_duty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:0] <= 8'(DUTY_MAX) && m_tdata[15:8] <= 8'(DUTY_MAX))
    else $error("duty out of range");

  a_servo: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[22:16] >= 7'(SERVO_MIN) && m_tdata[22:16] <= 7'(SERVO_MAX)
      && m_tdata[29:23] >= 7'(SERVO_MIN) && m_tdata[29:23] <= 7'(SERVO_MAX))
    else $error("servo command out of range");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind dual_wheel_pi_speed_with_pan_tilt_track pwst_chk u_pwst_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: dv/tb_dual_wheel_pi_speed_with_pan_tilt_track.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dual_wheel_pi_speed_with_pan_tilt_track - self-checking bench
// Walks a directed stimulus table, then randomized phases under several gain
// settings (all-ones, all-zero, random). Every accepted tick is predicted in
// the bench and each output word is checked field by field against the
// oldest expected word. Both stream sides idle at random, and the output side
// holds off for a long stretch once so that the block backs up its input.
// ----------------------------------------------------------------------------
module tb_dual_wheel_pi_speed_with_pan_tilt_track;
  import pwst_pkg::*;

  localparam int SPEED_BITS     = 11;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int IN_FIELDS_W    = 4 * SPEED_BITS + 2 * PIX_W;
  localparam int IN_TDATA_W     = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int INTEG_W        = INTEG_INT_BITS + GAIN_FRAC_BITS;
  localparam longint INTEG_HI   = (longint'(1) <<< (INTEG_W - 1)) - 1;
  localparam longint INTEG_LO   = -INTEG_HI - 1;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_LEN     = 400;
  localparam int QUIET_LO     = 300;
  localparam int QUIET_HI     = 420;
  localparam int PHASES       = 7;
  localparam int PHASE_TICKS  = 97;
  localparam int DRAIN_CYCLES = 30;
  localparam int IDLE_PCT     = 8;

  typedef struct packed {
    logic                  straight;
    logic                  seen;
    logic [PIX_W-1:0]      obj_y;
    logic [PIX_W-1:0]      obj_x;
    logic [SPEED_BITS-1:0] spd_r;
    logic [SPEED_BITS-1:0] spd_l;
    logic [SPEED_BITS-1:0] ord_r;
    logic [SPEED_BITS-1:0] ord_l;
  } tick_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  duty_l;
    logic [DUTY_W-1:0]  duty_r;
    logic [SERVO_W-1:0] pan;
    logic [SERVO_W-1:0] tilt;
  } drive_t;

  typedef struct packed {
    tick_t  t;
    logic   typed;
    drive_t want;
  } plan_row_t;

  logic                      clk;
  logic                      rst;
  logic                      s_tvalid;
  logic                      s_tready;
  // order_left, order_right, speed_left, speed_right, object_x, object_y
  logic [IN_TDATA_W-1:0]     s_tdata;
  // going_straight, object_seen
  logic [1:0]                s_tuser;
  logic                      m_tvalid;
  logic                      m_tready;
  // duty_left, duty_right, pan_cmd, tilt_cmd
  logic [OUT_TDATA_W-1:0]    m_tdata;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [GAIN_FRAC_BITS-1:0] cfg_data;

  longint kp_l, ki_l, kp_r, ki_r, slip;
  longint integ_l, integ_r;
  int     pan_pos, tilt_pos;

  drive_t    duty_q[$];
  plan_row_t plan[$];
  int        ticks_sent;
  int        words_checked;
  int        mismatches;
  int        sat_events;
  int        stop_events;
  int        gain_sets;
  int        cycle_count;
  bit        held;

  dual_wheel_pi_speed_with_pan_tilt_track #(
    .SPEED_BITS     (SPEED_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 50)
      $display("[%0t] %s", $time, msg);
  endtask

  task automatic run_wheel(input longint err, input longint kp, input longint ki,
                           inout longint integ, output logic [DUTY_W-1:0] duty);
    longint p, p_hi, p_lo, dint, acc;
    p    = kp * err;
    p_hi = p >>> GAIN_FRAC_BITS;
    p_lo = p - (p_hi <<< GAIN_FRAC_BITS);
    dint = ki * p_hi + ((ki * p_lo) >>> GAIN_FRAC_BITS);
    integ = integ + dint;
    if (integ > INTEG_HI) begin
      integ = INTEG_HI;
      sat_events++;
    end else if (integ < INTEG_LO) begin
      integ = INTEG_LO;
      sat_events++;
    end
    acc = (longint'(DUTY_STOP) <<< GAIN_FRAC_BITS) + integ + p;
    if (acc < 0) begin
      duty = '0;
    end else begin
      acc = acc >>> GAIN_FRAC_BITS;
      if (acc > DUTY_MAX) acc = DUTY_MAX;
      duty = acc[DUTY_W-1:0];
    end
  endtask

  task automatic predict_drive(input tick_t t, output drive_t r);
    longint ol, orr, sl, sr, err_l, err_r, corr;
    int dx, dy;
    ol  = $signed(t.ord_l);
    orr = $signed(t.ord_r);
    sl  = $signed(t.spd_l);
    sr  = $signed(t.spd_r);
    err_l = ol - sl;
    err_r = orr - sr;
    if (t.seen) begin
      dx = int'(t.obj_x) - CAM_WIDTH / 2;
      dy = int'(t.obj_y) - CAM_HEIGHT / 2;
      if (dx > DEADBAND) begin
        if (pan_pos > SERVO_MIN) pan_pos--; else stop_events++;
      end
      if (dx < -DEADBAND) begin
        if (pan_pos < SERVO_MAX) pan_pos++; else stop_events++;
      end
      if (dy > DEADBAND) begin
        if (tilt_pos < SERVO_MAX) tilt_pos++; else stop_events++;
      end
      if (dy < -DEADBAND) begin
        if (tilt_pos > SERVO_MIN) tilt_pos--; else stop_events++;
      end
    end
    if (t.straight) begin
      corr  = (sl - sr) * slip;
      err_l = err_l - corr;
      err_r = err_r + corr;
    end
    run_wheel(err_l, kp_l, ki_l, integ_l, r.duty_l);
    run_wheel(err_r, kp_r, ki_r, integ_r, r.duty_r);
    r.pan  = pan_pos[SERVO_W-1:0];
    r.tilt = tilt_pos[SERVO_W-1:0];
  endtask

  task automatic send_tick(input tick_t t, input logic typed, input drive_t want);
    drive_t r;
    bit quiet;
    quiet = ticks_sent >= QUIET_LO && ticks_sent < QUIET_HI;
    if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, t.obj_y, t.obj_x,
                 t.spd_r, t.spd_l, t.ord_r, t.ord_l};
    s_tuser  <= {t.seen, t.straight};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    predict_drive(t, r);
    duty_q.push_back(typed ? want : r);
    ticks_sent++;
  endtask

  task automatic drain_results();
    while (duty_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [GAIN_FRAC_BITS-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_KP_LEFT:  kp_l = data;
      REG_KI_LEFT:  ki_l = data;
      REG_KP_RIGHT: kp_r = data;
      REG_KI_RIGHT: ki_r = data;
      REG_SLIP:     slip = data[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_gains(input logic [15:0] kpl, input logic [15:0] kil,
                             input logic [15:0] kpr, input logic [15:0] kir,
                             input logic [15:0] slip_word);
    drain_results();
    write_reg(REG_KP_LEFT, kpl);
    write_reg(REG_KI_LEFT, kil);
    write_reg(REG_KP_RIGHT, kpr);
    write_reg(REG_KI_RIGHT, kir);
    write_reg(REG_SLIP, slip_word);
    write_reg(CFG_IDX_W'($urandom_range(REG_SLIP + 1, (1 << CFG_IDX_W) - 1)),
              GAIN_FRAC_BITS'($urandom));
    cfg_valid <= 1'b0;
    gain_sets++;
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [SPEED_BITS-1:0] rand_speed();
    case ($urandom_range(0, 19))
      0:       return '1;
      1:       return {1'b1, {(SPEED_BITS - 1){1'b0}}};
      2:       return {1'b0, {(SPEED_BITS - 1){1'b1}}};
      3:       return '0;
      default: return SPEED_BITS'($urandom);
    endcase
  endfunction

  // lean 1/2: straight with extreme opposite wheel speeds, drives the
  // integrators to their limits; aim 1 pulls pan up and tilt down
  function automatic tick_t rand_tick(input int lean, input int aim);
    tick_t t;
    t.ord_l    = rand_speed();
    t.ord_r    = rand_speed();
    t.spd_l    = rand_speed();
    t.spd_r    = rand_speed();
    t.straight = 1'($urandom_range(0, 1));
    t.seen     = $urandom_range(0, 9) != 0;
    t.obj_x    = PIX_W'($urandom);
    t.obj_y    = PIX_W'($urandom);
    if (lean == 1) begin
      t.straight = 1'b1;
      t.spd_l    = {1'b1, {(SPEED_BITS - 1){1'b0}}} + SPEED_BITS'($urandom_range(0, 123));
      t.spd_r    = {1'b0, {(SPEED_BITS - 1){1'b1}}} - SPEED_BITS'($urandom_range(0, 123));
    end else if (lean == 2) begin
      t.straight = 1'b1;
      t.spd_r    = {1'b1, {(SPEED_BITS - 1){1'b0}}} + SPEED_BITS'($urandom_range(0, 123));
      t.spd_l    = {1'b0, {(SPEED_BITS - 1){1'b1}}} - SPEED_BITS'($urandom_range(0, 123));
    end
    if (aim == 1 && $urandom_range(0, 4) != 0) begin
      t.obj_x = PIX_W'($urandom_range(0, 120));
      t.obj_y = PIX_W'($urandom_range(0, 130));
    end
    return t;
  endfunction

  function automatic plan_row_t mk_row(input int ol, input int orr, input int sl,
                                       input int sr, input bit st, input bit sn,
                                       input int x, input int y, input bit typed,
                                       input int dl, input int dr, input int pn,
                                       input int tl);
    plan_row_t row;
    row.t.ord_l       = SPEED_BITS'(ol);
    row.t.ord_r       = SPEED_BITS'(orr);
    row.t.spd_l       = SPEED_BITS'(sl);
    row.t.spd_r       = SPEED_BITS'(sr);
    row.t.straight    = st;
    row.t.seen        = sn;
    row.t.obj_x       = PIX_W'(x);
    row.t.obj_y       = PIX_W'(y);
    row.typed         = typed;
    row.want.duty_l   = DUTY_W'(dl);
    row.want.duty_r   = DUTY_W'(dr);
    row.want.pan      = SERVO_W'(pn);
    row.want.tilt     = SERVO_W'(tl);
    return row;
  endfunction

  initial begin
    held = 1'b0;
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!held && ticks_sent >= HOLD_AT) begin
        m_tready <= 1'b0;
        for (int n = 0; n < HOLD_LEN; n++) @(posedge clk);
        held = 1'b1;
      end else begin
        m_tready <= (ticks_sent >= QUIET_LO && ticks_sent < QUIET_HI) ||
                    $urandom_range(0, 99) >= IDLE_PCT;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    drive_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.duty_l = m_tdata[7:0];
      got.duty_r = m_tdata[15:8];
      got.pan    = m_tdata[22:16];
      got.tilt   = m_tdata[29:23];
      if (duty_q.size() == 0) begin
        flag_mismatch($sformatf("output word 0x%08h with no tick pending", m_tdata));
      end else begin
        want = duty_q.pop_front();
        if (got.duty_l !== want.duty_l)
          flag_mismatch($sformatf("word %0d duty_left %0d, want %0d",
                                  words_checked, got.duty_l, want.duty_l));
        if (got.duty_r !== want.duty_r)
          flag_mismatch($sformatf("word %0d duty_right %0d, want %0d",
                                  words_checked, got.duty_r, want.duty_r));
        if (got.pan !== want.pan)
          flag_mismatch($sformatf("word %0d pan_cmd %0d, want %0d",
                                  words_checked, got.pan, want.pan));
        if (got.tilt !== want.tilt)
          flag_mismatch($sformatf("word %0d tilt_cmd %0d, want %0d",
                                  words_checked, got.tilt, want.tilt));
        if (m_tdata[OUT_TDATA_W-1:30] !== '0)
          flag_mismatch($sformatf("word %0d padding bits 0x%08h",
                                  words_checked, m_tdata));
      end
      words_checked++;
    end
  end

  initial begin
    int lean, aim;
    drive_t none;
    none = '0;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    kp_l = KP_RESET_Q16;
    ki_l = KI_RESET_Q16;
    kp_r = KP_RESET_Q16;
    ki_r = KI_RESET_Q16;
    slip = SLIP_RESET;
    integ_l  = 0;
    integ_r  = 0;
    pan_pos  = SERVO_HOME;
    tilt_pos = SERVO_HOME;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    //             ol     orr    sl     sr    st sn  x    y   typed  expected
    plan.push_back(mk_row(0,     0,     0,     0,    0, 0, 0,   0,   1, 100, 100, 70, 70));
    plan.push_back(mk_row(0,     0,     0,     0,    0, 1, 130, 140, 1, 100, 100, 70, 70));
    plan.push_back(mk_row(0,     0,     0,     0,    0, 1, 150, 160, 1, 100, 100, 70, 70));
    plan.push_back(mk_row(0,     0,     0,     0,    0, 1, 110, 120, 1, 100, 100, 70, 70));
    plan.push_back(mk_row(0,     0,     0,     0,    0, 1, 151, 161, 1, 100, 100, 69, 71));
    plan.push_back(mk_row(0,     0,     0,     0,    0, 1, 109, 119, 1, 100, 100, 70, 70));
    plan.push_back(mk_row(0,     0,     0,     0,    0, 1, 0,   0,   1, 100, 100, 71, 69));
    plan.push_back(mk_row(0,     0,     0,     0,    0, 1, 511, 511, 1, 100, 100, 70, 70));
    plan.push_back(mk_row(0,     0,     0,     0,    1, 0, 0,   511, 1, 100, 100, 70, 70));
    plan.push_back(mk_row(1023,  -1024, -1024, 1023, 0, 0, 0,   0,   0, 0, 0, 0, 0));
    plan.push_back(mk_row(1023,  -1024, -1024, 1023, 1, 0, 0,   0,   0, 0, 0, 0, 0));
    plan.push_back(mk_row(-1024, 1023,  1023, -1024, 1, 1, 300, 20,  0, 0, 0, 0, 0));
    plan.push_back(mk_row(1023,  1023,  1023,  1023, 1, 1, 20,  300, 0, 0, 0, 0, 0));
    plan.push_back(mk_row(-1024, -1024, -1024, -1024, 1, 0, 511, 0,  0, 0, 0, 0, 0));
    plan.push_back(mk_row(-1,    1,     0,     0,    0, 1, 255, 256, 0, 0, 0, 0, 0));
    plan.push_back(mk_row(100,   100,   50,    40,   1, 1, 300, 20,  0, 0, 0, 0, 0));
    plan.push_back(mk_row(-1,    -1,    -1,    -1,   1, 1, 511, 511, 0, 0, 0, 0, 0));
    plan.push_back(mk_row(682,   -683,  -683,  682,  1, 1, 170, 341, 0, 0, 0, 0, 0));

    foreach (plan[i])
      send_tick(plan[i].t, plan[i].typed, plan[i].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      s_tvalid <= 1'b0;
      case (ph)
        0:       apply_gains('1, '1, '1, '1, '1);
        1:       apply_gains('0, '0, '0, '0, '0);
        2:       apply_gains(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 40000)),
                             16'($urandom_range(0, 2000)), 16'($urandom_range(0, 40000)),
                             16'($urandom_range(0, 40)));
        default: apply_gains(pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                             16'($urandom));
      endcase
      aim = ph % 2;
      for (int n = 0; n < PHASE_TICKS; n++) begin
        if (ph == 0 && n < 40)
          lean = 1;
        else if (ph == 0 && n < 80)
          lean = 2;
        else
          lean = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 2) : 0;
        send_tick(rand_tick(lean, aim), 1'b0, none);
      end
    end
    s_tvalid <= 1'b0;

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d ticks under %0d gain settings, checked %0d output words, %0d mismatches",
             ticks_sent, gain_sets + 1, words_checked, mismatches);
    $display("Integrator clamps predicted: %0d, servo end-stop holds: %0d",
             sat_events, stop_events);
    if (mismatches == 0 && duty_q.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/pwst_pkg.sv
rtl/core/pwst_mul.sv
rtl/core/pwst_servo.sv
rtl/core/dual_wheel_pi_speed_with_pan_tilt_track.sv
rtl/core/pwst_chk.sv
dv/tb_dual_wheel_pi_speed_with_pan_tilt_track.sv
